// File: hw/rtl/http_request_header_tokenizer_macros.svh
// assertion macros used by the tokenizer checker
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HRHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrht check failed");

// next-cycle implication, disabled while reset is asserted
`define HRHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrht check failed");

`endif

// File: hw/rtl/hrht_pkg.sv
// types, codes and match tables for the http request header tokenizer
package hrht_pkg;

    // field kinds on the result channel
    localparam logic [3:0] K_METHOD    = 4'd0;
    localparam logic [3:0] K_SCHEME    = 4'd1;
    localparam logic [3:0] K_HOST      = 4'd2;
    localparam logic [3:0] K_PORT      = 4'd3;
    localparam logic [3:0] K_PATH      = 4'd4;
    localparam logic [3:0] K_NAME      = 4'd5;
    localparam logic [3:0] K_VALUE     = 4'd6;
    localparam logic [3:0] K_NAME_END  = 4'd7;
    localparam logic [3:0] K_VALUE_END = 4'd8;
    localparam logic [3:0] K_HDR_END   = 4'd9;
    localparam logic [3:0] K_BODY      = 4'd10;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0]  TUNNEL_LEN  = 4'd7;
    localparam logic [3:0]  SECURE_LEN  = 4'd5;
    localparam logic [3:0]  MATCH_FAIL  = 4'd15;
    localparam logic [15:0] SECURE_PORT = 16'd443;
    localparam logic [15:0] PLAIN_PORT  = 16'd80;
    localparam logic [15:0] PORT_MAX    = 16'hffff;

    typedef enum logic [1:0] {
        PH_LINE,
        PH_NAME,
        PH_VALUE,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        LP_METHOD,
        LP_SCHEME,
        LP_HOST,
        LP_PORT,
        LP_PATH
    } t_line_part;

    typedef enum logic [1:0] {
        PS_NONE,
        PS_DIGITS,
        PS_ENDED,
        PS_NAN
    } t_port_status;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [3:0]  field_kind;
        logic        is_tunnel;
        logic [15:0] server_port;
        logic        last;
    } t_result;

    // running compare against "CONNECT"
    function automatic logic [3:0] tunnel_step(input logic [3:0] m, input logic [7:0] ch);
        logic [7:0] want;
        case (m)
            4'd0: want = "C";
            4'd1: want = "O";
            4'd2: want = "N";
            4'd3: want = "N";
            4'd4: want = "E";
            4'd5: want = "C";
            4'd6: want = "T";
            default: want = 8'h00;
        endcase
        return (m < TUNNEL_LEN && ch == want) ? m + 4'd1 : MATCH_FAIL;
    endfunction

    // running compare against "https"
    function automatic logic [3:0] secure_step(input logic [3:0] m, input logic [7:0] ch);
        logic [7:0] want;
        case (m)
            4'd0: want = "h";
            4'd1: want = "t";
            4'd2: want = "t";
            4'd3: want = "p";
            4'd4: want = "s";
            default: want = 8'h00;
        endcase
        return (m < SECURE_LEN && ch == want) ? m + 4'd1 : MATCH_FAIL;
    endfunction

endpackage

// File: hw/rtl/hrht_if.sv
// request and result channel interfaces of the tokenizer
interface hrht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_request;

    modport source (output valid, output data_byte, output new_request, input ready);
    modport sink (input valid, input data_byte, input new_request, output ready);
endinterface

interface hrht_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [3:0]  field_kind;
    logic        is_tunnel;
    logic [15:0] server_port;
    logic        last;

    modport source (output valid, output out_byte, output field_kind, output is_tunnel,
                    output server_port, output last, input ready);
    modport sink (input valid, input out_byte, input field_kind, input is_tunnel,
                  input server_port, input last, output ready);
endinterface

// File: hw/rtl/hrht_parse.sv
// per-byte parser state and result generation
module hrht_parse
    import hrht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_request,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_cnt
);

    t_phase       r_phase, n_phase, c_phase;
    t_line_part   r_line_part, n_line_part, c_line_part;
    t_port_status r_port_status, n_port_status, c_port_status;
    logic         r_slash_seen, n_slash_seen, c_slash_seen;
    logic         r_path_started, n_path_started, c_path_started;
    logic         r_name_started, n_name_started, c_name_started;
    logic         r_value_started, n_value_started, c_value_started;
    logic [3:0]   r_method_match, n_method_match, c_method_match;
    logic [3:0]   r_scheme_match, n_scheme_match, c_scheme_match;
    logic [15:0]  r_port_value, n_port_value, c_port_value;
    logic         r_tunnel, n_tunnel, c_tunnel;

    logic [7:0]   ch;
    logic         is_digit;
    logic [19:0]  port_mac;
    logic         e_valid;
    logic [7:0]   e_byte;
    logic [3:0]   e_kind;
    logic         e_tun;
    logic [15:0]  e_port;
    logic         e_slash;
    t_result      main_res;

    assign ch       = i_data_byte;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    // value * 10 + digit
    assign port_mac = {c_port_value, 3'b000} + {2'b00, c_port_value, 1'b0}
                    + {16'd0, ch[3:0]};

    always_comb begin
        // a new request starts from the reset state before this byte
        c_phase         = i_new_request ? PH_LINE : r_phase;
        c_line_part     = i_new_request ? LP_METHOD : r_line_part;
        c_port_status   = i_new_request ? PS_NONE : r_port_status;
        c_slash_seen    = i_new_request ? 1'b0 : r_slash_seen;
        c_path_started  = i_new_request ? 1'b0 : r_path_started;
        c_name_started  = i_new_request ? 1'b0 : r_name_started;
        c_value_started = i_new_request ? 1'b0 : r_value_started;
        c_method_match  = i_new_request ? 4'd0 : r_method_match;
        c_scheme_match  = i_new_request ? 4'd0 : r_scheme_match;
        c_port_value    = i_new_request ? 16'd0 : r_port_value;
        c_tunnel        = i_new_request ? 1'b0 : r_tunnel;

        n_phase         = c_phase;
        n_line_part     = c_line_part;
        n_port_status   = c_port_status;
        n_slash_seen    = c_slash_seen;
        n_path_started  = c_path_started;
        n_name_started  = c_name_started;
        n_value_started = c_value_started;
        n_method_match  = c_method_match;
        n_scheme_match  = c_scheme_match;
        n_port_value    = c_port_value;
        n_tunnel        = c_tunnel;

        e_valid = 1'b0;
        e_byte  = ch;
        e_kind  = K_BODY;
        e_tun   = 1'b0;
        e_port  = 16'd0;
        e_slash = 1'b0;

        case (c_phase)
            PH_LINE: begin
                if (ch == CH_CR) begin
                end else if (ch == CH_LF) begin
                    n_phase         = PH_NAME;
                    n_name_started  = 1'b0;
                    n_value_started = 1'b0;
                end else begin
                    case (c_line_part)
                        LP_METHOD: begin
                            if (ch == CH_SPACE) begin
                                if (c_method_match == TUNNEL_LEN) begin
                                    n_tunnel    = 1'b1;
                                    n_line_part = LP_HOST;
                                end else begin
                                    n_line_part = LP_SCHEME;
                                end
                            end else begin
                                n_method_match = tunnel_step(c_method_match, ch);
                                e_valid        = 1'b1;
                                e_kind         = K_METHOD;
                            end
                        end
                        LP_SCHEME: begin
                            if (ch == CH_COLON) begin
                            end else if (ch == CH_SLASH) begin
                                if (c_slash_seen) begin
                                    n_line_part = LP_HOST;
                                end
                                n_slash_seen = 1'b1;
                            end else begin
                                n_scheme_match = secure_step(c_scheme_match, ch);
                                e_valid        = 1'b1;
                                e_kind         = K_SCHEME;
                            end
                        end
                        LP_HOST: begin
                            if (ch == CH_COLON) begin
                                n_line_part = LP_PORT;
                            end else if (ch == CH_SLASH || ch == CH_SPACE) begin
                                n_line_part = LP_PATH;
                            end else begin
                                e_valid = 1'b1;
                                e_kind  = K_HOST;
                            end
                        end
                        LP_PORT: begin
                            if (ch == CH_SLASH || ch == CH_SPACE) begin
                                n_line_part = LP_PATH;
                            end else begin
                                e_valid = 1'b1;
                                e_kind  = K_PORT;
                                case (c_port_status)
                                    PS_NONE: begin
                                        // leading tab, vt and ff are skipped
                                        if (ch == CH_TAB || ch == CH_VT || ch == CH_FF) begin
                                        end else if (is_digit) begin
                                            n_port_value  = {12'd0, ch[3:0]};
                                            n_port_status = PS_DIGITS;
                                        end else begin
                                            n_port_status = PS_NAN;
                                        end
                                    end
                                    PS_DIGITS: begin
                                        if (is_digit) begin
                                            n_port_value = (port_mac > {4'd0, PORT_MAX})
                                                         ? PORT_MAX : port_mac[15:0];
                                        end else begin
                                            n_port_status = PS_ENDED;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        default: begin
                            // path takes the rest of the line, slash first once
                            e_valid        = 1'b1;
                            e_kind         = K_PATH;
                            e_slash        = !c_path_started;
                            n_path_started = 1'b1;
                        end
                    endcase
                end
            end
            PH_NAME: begin
                if (ch == CH_CR) begin
                end else if (ch == CH_LF) begin
                    if (!c_name_started) begin
                        n_phase = PH_BODY;
                        e_valid = 1'b1;
                        e_byte  = 8'd0;
                        e_kind  = K_HDR_END;
                        e_tun   = c_tunnel;
                        if (c_port_status == PS_DIGITS || c_port_status == PS_ENDED) begin
                            e_port = c_port_value;
                        end else begin
                            e_port = (c_scheme_match == SECURE_LEN) ? SECURE_PORT : PLAIN_PORT;
                        end
                    end
                end else if (ch == CH_COLON) begin
                    n_phase         = PH_VALUE;
                    n_name_started  = 1'b0;
                    n_value_started = 1'b0;
                    e_valid         = 1'b1;
                    e_byte          = 8'd0;
                    e_kind          = K_NAME_END;
                end else begin
                    n_name_started = 1'b1;
                    e_valid        = 1'b1;
                    e_kind         = K_NAME;
                end
            end
            PH_VALUE: begin
                if (ch == CH_CR) begin
                end else if (ch == CH_LF) begin
                    n_phase         = PH_NAME;
                    n_value_started = 1'b0;
                    e_valid         = 1'b1;
                    e_byte          = 8'd0;
                    e_kind          = K_VALUE_END;
                end else if (!c_value_started && ch == CH_SPACE) begin
                end else begin
                    n_value_started = 1'b1;
                    e_valid         = 1'b1;
                    e_kind          = K_VALUE;
                end
            end
            default: begin
                e_valid = 1'b1;
                e_kind  = K_BODY;
            end
        endcase

        main_res = '{out_byte: e_byte, field_kind: e_kind, is_tunnel: e_tun,
                     server_port: e_port, last: 1'b1};
        if (e_slash) begin
            o_res0 = '{out_byte: CH_SLASH, field_kind: K_PATH, is_tunnel: 1'b0,
                       server_port: 16'd0, last: 1'b0};
            o_res1 = main_res;
            o_cnt  = 2'd2;
        end else begin
            o_res0 = main_res;
            o_res1 = main_res;
            o_cnt  = {1'b0, e_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LINE;
            r_line_part     <= LP_METHOD;
            r_port_status   <= PS_NONE;
            r_slash_seen    <= 1'b0;
            r_path_started  <= 1'b0;
            r_name_started  <= 1'b0;
            r_value_started <= 1'b0;
            r_method_match  <= 4'd0;
            r_scheme_match  <= 4'd0;
            r_port_value    <= 16'd0;
            r_tunnel        <= 1'b0;
        end else if (i_take) begin
            r_phase         <= n_phase;
            r_line_part     <= n_line_part;
            r_port_status   <= n_port_status;
            r_slash_seen    <= n_slash_seen;
            r_path_started  <= n_path_started;
            r_name_started  <= n_name_started;
            r_value_started <= n_value_started;
            r_method_match  <= n_method_match;
            r_scheme_match  <= n_scheme_match;
            r_port_value    <= n_port_value;
            r_tunnel        <= n_tunnel;
        end
    end

endmodule

// File: hw/rtl/hrht_fifo.sv
// four-entry result queue, up to two pushes and one pop per cycle
module hrht_fifo
    import hrht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_result    o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    // room for a request that makes two results
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    assign n_wr_ptr = r_wr_ptr + i_push_cnt;
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop};
    assign n_count  = r_count + {1'b0, i_push_cnt} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: hw/rtl/http_request_header_tokenizer.sv
// top level of the http request header tokenizer
//
//  channel | dir | payload                                              | accepted when
//  i_req   | in  | data_byte, new_request                               | valid && ready
//  o_res   | out | out_byte, field_kind, is_tunnel, server_port, last   | valid && ready
//
// one request per cycle while ready is high; a taken request's results are registered in the result queue
// a request makes zero, one or two results; the first path byte makes two
// ready follows the four-entry result queue: it is high while at least two entries are free
// a stall on o_res holds the queue head; i_req keeps flowing until fewer than two entries are free
// i_rst_n is synchronous and returns the parser to the start of a request line
module http_request_header_tokenizer
    import hrht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrht_in_if.sink    i_req,
    hrht_out_if.source o_res
);

    logic       take;
    logic       room;
    logic       head_valid;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    t_result    res0;
    t_result    res1;
    t_result    head;

    assign i_req.ready = room;
    assign take        = i_req.valid && room;
    assign push_cnt    = take ? res_cnt : 2'd0;

    hrht_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_req.data_byte),
        .i_new_request (i_req.new_request),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_cnt         (res_cnt)
    );

    hrht_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (o_res.ready),
        .o_room     (room),
        .o_valid    (head_valid),
        .o_head     (head)
    );

    assign o_res.valid       = head_valid;
    assign o_res.out_byte    = head.out_byte;
    assign o_res.field_kind  = head.field_kind;
    assign o_res.is_tunnel   = head.is_tunnel;
    assign o_res.server_port = head.server_port;
    assign o_res.last        = head.last;

endmodule

// File: hw/rtl/hrht_checker.sv
// port-level checks on the tokenizer result channel, bound to the top level
`include "http_request_header_tokenizer_macros.svh"

module hrht_checker
    import hrht_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic [3:0]  i_field_kind,
    input logic        i_is_tunnel,
    input logic [15:0] i_server_port,
    input logic        i_last
);

    logic res_event;
    logic res_hdr_end;
    logic port_clear;
    logic slash_res;

    assign res_hdr_end = (i_field_kind == K_HDR_END);
    assign res_event   = (i_field_kind == K_NAME_END) || (i_field_kind == K_VALUE_END)
                       || res_hdr_end;
    assign port_clear  = (i_server_port == 16'd0) && !i_is_tunnel;
    assign slash_res   = (i_field_kind == K_PATH) && (i_out_byte == CH_SLASH);

    // a stalled result stays offered
    `HRHT_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // events are always the only result of their request
    `HRHT_ASSERT_IMP(a_event_last, i_clk, i_rst_n, i_out_valid && res_event, i_last)

    // port and tunnel flag only ride on headers end
    `HRHT_ASSERT_IMP(a_port_only_end, i_clk, i_rst_n, i_out_valid && !res_hdr_end, port_clear)

    // the only non-final result is the inserted path slash
    `HRHT_ASSERT_IMP(a_slash_first, i_clk, i_rst_n, i_out_valid && !i_last, slash_res)

endmodule

bind http_request_header_tokenizer hrht_checker u_hrht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_byte    (o_res.out_byte),
    .i_field_kind  (o_res.field_kind),
    .i_is_tunnel   (o_res.is_tunnel),
    .i_server_port (o_res.server_port),
    .i_last        (o_res.last)
);
